/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an expression is never true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/core/lzwc_pkg.sv */
package lzwc_pkg;
	localparam int BYTE_W      = 8;
	localparam int START_WIDTH = 9;
	localparam int START_POINT = 512;
	localparam int INC_W       = 9;
	localparam logic [INC_W-1:0] INC_RESET = 9'd257;

	// One queued input byte
	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] data;
	} item_t;

	// Dictionary engine sequence
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH_RD,
		ST_HASH_CHK,
		ST_DICT_CHK,
		ST_MISS,
		ST_EMIT_PFX,
		ST_EMIT_INC,
		ST_FLUSH_CODE,
		ST_FLUSH_END
	} eng_state_t;
endpackage

/* rtl/core/lzwc_ram.sv */
module lzwc_ram import lzwc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/lzwc_front.sv */
module lzwc_front import lzwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hold,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              s_tlast,
	output item_t             q_item,
	output logic              q_valid,
	input  logic              q_pop
);
	item_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign s_tready = (cnt_q != 2'd2) && !hold;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_q];

	// Store each transfer in a two-entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= '{last: s_tlast, data: s_tdata};
		end
	end

	// Advance the pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

/* rtl/core/lzwc_packer.sv */
module lzwc_packer import lzwc_pkg::*; #(
	parameter int PFX_W = 12,
	parameter int WID_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  logic              op_flush,
	input  logic [PFX_W-1:0]  op_code,
	input  logic [WID_W-1:0]  op_width,
	output logic              op_ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tlast
);
	localparam int ACC_W  = 7 + PFX_W + 1;
	localparam int HELD_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0]  acc_q;
	logic [HELD_W-1:0] held_q;
	logic              fin_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_free;
	logic              has_byte;
	logic              load;
	logic [ACC_W-1:0]  code_ext;
	logic [ACC_W-1:0]  mask;

	assign out_free = !out_valid_q || m_tready;
	assign has_byte = (held_q >= HELD_W'(8));
	assign op_ready = !has_byte && !fin_q;
	assign load     = !(op_valid && op_ready) && out_free && (has_byte || fin_q);
	assign code_ext = ACC_W'(op_code);
	assign mask     = ~({ACC_W{1'b1}} << op_width);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Output byte register
	always_ff @(posedge clk) begin
		if (!(op_valid && op_ready) && out_free) begin
			if (has_byte) begin
				out_data_q <= BYTE_W'(acc_q >> (held_q - HELD_W'(8)));
				out_last_q <= 1'b0;
			end else if (fin_q) begin
				out_data_q <= BYTE_W'(acc_q << (HELD_W'(8) - held_q));
				out_last_q <= 1'b1;
			end
		end
	end

	// Append codes, drain whole bytes, pad the tail on flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			held_q      <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (op_valid && op_ready) begin
				if (op_flush) begin
					fin_q <= 1'b1;
				end else begin
					acc_q  <= (acc_q << op_width) | (code_ext & mask);
					held_q <= held_q + HELD_W'(op_width);
				end
			end else if (out_free && has_byte) begin
				held_q <= held_q - HELD_W'(8);
			end else if (out_free && fin_q) begin
				acc_q  <= '0;
				held_q <= '0;
				fin_q  <= 1'b0;
			end
		end
	end
endmodule

/* rtl/core/lzwc_engine.sv */
module lzwc_engine import lzwc_pkg::*; #(
	parameter int DICT_SIZE       = 4096,
	parameter int FIRST_FREE_CODE = 258,
	parameter int PFX_W           = 12,
	parameter int WID_W           = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            q_item,
	input  logic             q_valid,
	output logic             q_pop,
	input  logic [INC_W-1:0] increase_code,
	output logic             op_valid,
	output logic             op_flush,
	output logic [PFX_W-1:0] op_code,
	output logic [WID_W-1:0] op_width,
	input  logic             op_ready,
	output logic             clearing
);
	localparam int NC_W   = PFX_W + 1;
	localparam int WP_W   = PFX_W + 2;
	localparam int KEY_W  = PFX_W + BYTE_W;
	localparam int HASH_W = PFX_W + 1;
	localparam int HASH_D = 1 << HASH_W;
	localparam int DENT_W = HASH_W + KEY_W;

	eng_state_t        state_q, state_d;
	logic [PFX_W-1:0]  prefix_q;
	logic              have_q;
	logic [NC_W-1:0]   next_q;
	logic [WID_W-1:0]  width_q;
	logic [WP_W-1:0]   wp_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [HASH_W-1:0] slot_q;
	logic [PFX_W-1:0]  sc_q;
	logic [HASH_W-1:0] clr_q;

	logic [KEY_W-1:0]  key;
	logic              room;
	logic              h_we;
	logic [HASH_W-1:0] h_waddr;
	logic [PFX_W-1:0]  h_wdata;
	logic [PFX_W-1:0]  h_rdata;
	logic              d_we;
	logic [DENT_W-1:0] d_rdata;
	logic              sc_live;
	logic              slot_own;
	logic              key_hit;
	logic              widen;

	assign key      = {prefix_q, byte_q};
	assign room     = (next_q < NC_W'(DICT_SIZE));
	assign sc_live  = (h_rdata >= PFX_W'(FIRST_FREE_CODE)) && (NC_W'(h_rdata) < next_q);
	assign slot_own = (d_rdata[DENT_W-1:KEY_W] == slot_q);
	assign key_hit  = (d_rdata[KEY_W-1:0] == key);
	assign widen    = (WP_W'(next_q) == wp_q);
	assign clearing = (state_q == ST_CLEAR);

	// Hash slots hold codes; a slot is live only if its code points back to it
	assign h_we    = (state_q == ST_CLEAR) || ((state_q == ST_MISS) && room);
	assign h_waddr = (state_q == ST_CLEAR) ? clr_q : slot_q;
	assign h_wdata = (state_q == ST_CLEAR) ? '0 : next_q[PFX_W-1:0];
	assign d_we    = (state_q == ST_MISS) && room;

	lzwc_ram #(.WIDTH(PFX_W), .DEPTH(HASH_D)) u_hash (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (slot_q),
		.rdata (h_rdata)
	);

	lzwc_ram #(.WIDTH(DENT_W), .DEPTH(DICT_SIZE)) u_dict (
		.clk   (clk),
		.we    (d_we),
		.waddr (next_q[PFX_W-1:0]),
		.wdata ({slot_q, key}),
		.raddr (h_rdata),
		.rdata (d_rdata)
	);

	// Next state and code requests
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		op_valid = 1'b0;
		op_flush = 1'b0;
		op_code  = prefix_q;
		op_width = width_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == HASH_W'(HASH_D - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (!have_q) begin
						state_d = q_item.last ? ST_FLUSH_CODE : ST_IDLE;
					end else begin
						state_d = ST_HASH_RD;
					end
				end
			end
			ST_HASH_RD:  state_d = ST_HASH_CHK;
			ST_HASH_CHK: state_d = sc_live ? ST_DICT_CHK : ST_MISS;
			ST_DICT_CHK: begin
				if (!slot_own) begin
					state_d = ST_MISS;
				end else if (key_hit) begin
					state_d = last_q ? ST_FLUSH_CODE : ST_IDLE;
				end else begin
					state_d = ST_HASH_RD;
				end
			end
			ST_MISS: state_d = ST_EMIT_PFX;
			ST_EMIT_PFX: begin
				op_valid = 1'b1;
				if (op_ready) begin
					if (widen) begin
						state_d = ST_EMIT_INC;
					end else begin
						state_d = last_q ? ST_FLUSH_CODE : ST_IDLE;
					end
				end
			end
			ST_EMIT_INC: begin
				op_valid = 1'b1;
				op_code  = PFX_W'(increase_code);
				if (op_ready) begin
					state_d = last_q ? ST_FLUSH_CODE : ST_IDLE;
				end
			end
			ST_FLUSH_CODE: begin
				op_valid = 1'b1;
				if (op_ready) begin
					state_d = ST_FLUSH_END;
				end
			end
			ST_FLUSH_END: begin
				op_valid = 1'b1;
				op_flush = 1'b1;
				if (op_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the item being worked on and the probe position
	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= q_item.data;
			last_q <= q_item.last;
		end
		if (state_q == ST_HASH_CHK) begin
			sc_q <= h_rdata;
		end
		if ((state_q == ST_IDLE) && q_valid) begin
			slot_q <= HASH_W'({q_item.data, prefix_q})
				^ HASH_W'({q_item.data, prefix_q} >> HASH_W);
		end else if ((state_q == ST_DICT_CHK) && slot_own && !key_hit) begin
			slot_q <= slot_q + HASH_W'(1);
		end else if (state_q == ST_HASH_RD) begin
			slot_q <= slot_q;
		end
	end

	// Stream state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			prefix_q <= '0;
			have_q   <= 1'b0;
			next_q   <= NC_W'(FIRST_FREE_CODE);
			width_q  <= WID_W'(START_WIDTH);
			wp_q     <= WP_W'(START_POINT);
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + HASH_W'(1);
				ST_IDLE: begin
					if (q_valid && !have_q) begin
						prefix_q <= PFX_W'(q_item.data);
						have_q   <= 1'b1;
					end
				end
				ST_DICT_CHK: begin
					if (slot_own && key_hit) begin
						prefix_q <= sc_q;
					end
				end
				ST_MISS: begin
					if (room) begin
						next_q <= next_q + NC_W'(1);
					end
				end
				ST_EMIT_PFX: begin
					if (op_ready && !widen) begin
						prefix_q <= PFX_W'(byte_q);
					end
				end
				ST_EMIT_INC: begin
					if (op_ready) begin
						width_q  <= width_q + WID_W'(1);
						wp_q     <= wp_q << 1;
						prefix_q <= PFX_W'(byte_q);
					end
				end
				ST_FLUSH_END: begin
					if (op_ready) begin
						prefix_q <= '0;
						have_q   <= 1'b0;
						next_q   <= NC_W'(FIRST_FREE_CODE);
						width_q  <= WID_W'(START_WIDTH);
						wp_q     <= WP_W'(START_POINT);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

/* rtl/core/lzw_byte_compressor_unit.sv */
// Input bytes go into a two-entry queue, so a new byte can be taken while the
// engine still works on earlier ones. A byte is looked up by a hash read, a hash
// check and a dictionary check; a miss adds a miss step and a code emit. A code
// waits while the packer drains bytes, 1 a cycle while the receiver takes them.
// Reset: asynchronous, active low; then a clearing pass over all 2**($clog2(DICT_SIZE)+1)
// hash slots during which no byte is taken (configuration still is).
`include "assert_macros.svh"
module lzw_byte_compressor_unit import lzwc_pkg::*; #(
	parameter int DICT_SIZE       = 4096,
	parameter int FIRST_FREE_CODE = 258
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // in_byte
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // out_byte
	output logic              m_tlast,
	input  logic              cfg_we,
	input  logic [INC_W-1:0]  cfg_wdata
);
	localparam int PFX_W = $clog2(DICT_SIZE);
	localparam int WID_W = $clog2(PFX_W + 2);

	logic [INC_W-1:0] inc_q;
	item_t            q_item;
	logic             q_valid;
	logic             q_pop;
	logic             op_valid;
	logic             op_flush;
	logic [PFX_W-1:0] op_code;
	logic [WID_W-1:0] op_width;
	logic             op_ready;
	logic             clearing;

	// Increase-code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= INC_RESET;
		end else if (cfg_we) begin
			inc_q <= cfg_wdata;
		end
	end

	lzwc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (clearing),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop)
	);

	lzwc_engine #(
		.DICT_SIZE       (DICT_SIZE),
		.FIRST_FREE_CODE (FIRST_FREE_CODE),
		.PFX_W           (PFX_W),
		.WID_W           (WID_W)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (q_item),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.increase_code (inc_q),
		.op_valid      (op_valid),
		.op_flush      (op_flush),
		.op_code       (op_code),
		.op_width      (op_width),
		.op_ready      (op_ready),
		.clearing      (clearing)
	);

	lzwc_packer #(
		.PFX_W (PFX_W),
		.WID_W (WID_W)
	) u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_flush (op_flush),
		.op_code  (op_code),
		.op_width (op_width),
		.op_ready (op_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`ASSERT_PROP(a_pop_nonempty, clk, arst_n, q_pop |-> q_valid, "pop from empty queue")
	`ASSERT_NEVER(a_no_pop_clear, clk, arst_n, clearing && q_pop, "byte taken while clearing")
	`ASSERT_PROP(a_width_range, clk, arst_n, (op_valid && !op_flush) |-> (op_width >= WID_W'(START_WIDTH)) && (op_width <= WID_W'(PFX_W + 1)), "code width out of range")
endmodule

/* tb/tb_lzw_byte_compressor_unit.sv */
`timescale 1ns / 1ps

import lzwc_pkg::*;

typedef struct {
	logic [BYTE_W-1:0] data;
	logic              last;
} packed_byte_t;

// Scoreboard: predicts the packed code stream and checks the output transfers
class lzw_scoreboard;
	logic [INC_W-1:0]  inc_code;
	logic [11:0]       prefix;
	bit                have_prefix;
	int                next_code;
	int                code_w;
	int                widen_at;
	longint unsigned   acc;
	int                held;
	int                code_of[int];
	packed_byte_t      expected_bytes[$];
	int                errors;

	function new();
		inc_code = INC_RESET;
		errors = 0;
		clear_stream();
	endfunction

	function void clear_stream();
		prefix = '0;
		have_prefix = 0;
		next_code = 258;
		code_w = START_WIDTH;
		widen_at = START_POINT;
		acc = 0;
		held = 0;
		code_of.delete();
	endfunction

	function void push_byte(logic [BYTE_W-1:0] b, logic l);
		packed_byte_t e;
		e.data = b;
		e.last = l;
		expected_bytes.push_back(e);
	endfunction

	// Append a code MSB first, then send every whole byte held
	function void pack_code(int code);
		longint unsigned mask;
		mask = (64'd1 << code_w) - 1;
		acc = (acc << code_w) | (longint'(code) & mask);
		held += code_w;
		while (held >= 8) begin
			held -= 8;
			push_byte(BYTE_W'(acc >> held), 1'b0);
		end
		acc &= (64'd1 << held) - 1;
	endfunction

	function void note_input(logic [BYTE_W-1:0] b, logic l);
		int key;
		if (!have_prefix) begin
			prefix = 12'(b);
			have_prefix = 1;
		end else begin
			key = (int'(prefix) << 8) | int'(b);
			if (code_of.exists(key)) begin
				prefix = 12'(code_of[key]);
			end else begin
				// store the pair while room remains, then emit the prefix
				if (next_code < 4096) begin
					code_of[key] = next_code;
					next_code++;
				end
				pack_code(int'(prefix));
				if (next_code == widen_at) begin
					pack_code(int'(inc_code));
					code_w++;
					widen_at <<= 1;
				end
				prefix = 12'(b);
			end
		end
		// flush the pending code and zero-pad the tail
		if (l) begin
			pack_code(int'(prefix));
			push_byte(BYTE_W'(acc << (8 - held)), 1'b1);
			clear_stream();
		end
	endfunction

	function void check_output(logic [BYTE_W-1:0] b, logic l);
		packed_byte_t e;
		if (expected_bytes.size() == 0) begin
			$display("%0t: unexpected output byte %h last %b", $time, b, l);
			errors++;
			return;
		end
		e = expected_bytes.pop_front();
		if (e.data !== b) begin
			$display("%0t: out_byte expected %h actual %h", $time, e.data, b);
			errors++;
		end
		if (e.last !== l) begin
			$display("%0t: last_out expected %b actual %b", $time, e.last, l);
			errors++;
		end
	endfunction
endclass

module tb_lzw_byte_compressor_unit;
	logic              clk = 0;
	logic              arst_n = 0;
	logic              s_tvalid = 0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;   // in_byte
	logic              s_tlast = 0;
	logic              m_tvalid;
	logic              m_tready = 0;
	logic [BYTE_W-1:0] m_tdata;        // out_byte
	logic              m_tlast;
	logic              cfg_we = 0;
	logic [INC_W-1:0]  cfg_wdata = '0;

	lzw_scoreboard sb = new();
	int burst_left = 0;
	int quiet_cycles = 0;
	int stall_mode = 0;
	int cyc = 0;

	lzw_byte_compressor_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Note input transfers and check output transfers
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_output(m_tdata, m_tlast);
	end

	// Receiver stalls: switch between patterns now and then
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 300 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (cyc % 7 < 3);
			default: m_tready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	// Watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 30000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Hold each byte until transferred; bursts with random gaps between them
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_inc(input logic [INC_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.inc_code = v;
	endtask

	// Random stream: small alphabet for dictionary hits, or full range
	task automatic random_stream(input int len);
		int base;
		int span;
		base = $urandom_range(0, 255);
		span = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 4);
		for (int i = 0; i < len; i++)
			send_byte(BYTE_W'(base + $urandom_range(0, span)), i == len - 1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_inc(INC_RESET);

		// Directed: single-byte streams at the extremes, repeats, two-byte runs
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h80, 1'b1);
		for (int i = 0; i < 8; i++) send_byte(8'h61, i == 7);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		for (int i = 0; i < 6; i++) send_byte((i % 2) ? 8'h55 : 8'haa, i == 5);

		// Distinct pairs drive the next code to the widening point
		write_inc(9'd256);
		for (int i = 0; i < 258; i++) send_byte(BYTE_W'(i), i == 257);

		// Short streams at the top and at a colliding increase code
		write_inc(9'd511);
		for (int n = 0; n < 2; n++) random_stream($urandom_range(1, 8));
		write_inc(9'd300);
		for (int n = 0; n < 2; n++) random_stream($urandom_range(1, 8));

		drain();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lzwc_pkg.sv
rtl/core/lzwc_ram.sv
rtl/core/lzwc_front.sv
rtl/core/lzwc_packer.sv
rtl/core/lzwc_engine.sv
rtl/core/lzw_byte_compressor_unit.sv
tb/tb_lzw_byte_compressor_unit.sv
